/* src/bfm_pkg.sv */
// Shared types, limits and codes for the battery fault monitor.
package bfm_pkg;

    // Fixed protection limits.
    localparam int DISCHARGE_LIMIT_MV   = 3100;
    localparam int UV_HYSTERESIS_MV     = 100;
    localparam int TEMP_HYSTERESIS_DECI = 50;
    localparam int MODULE_SLOTS         = 20;
    localparam int OV_CLEAR_MV          = 100;
    localparam int SANE_LIMIT_MV        = 10000;
    localparam int DEBOUNCE_MS          = 1000;
    localparam int GRACE_MS             = 10000;

    // Field widths.
    localparam int MV_W     = 16;
    localparam int LIM_MV_W = 14;
    localparam int TEMP_W   = 12;
    localparam int TIME_W   = 32;
    localparam int MOD_W    = 20;
    localparam int CODE_W   = 3;

    // Configuration port widths.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_OVER_VOLTAGE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_UNDER_VOLTAGE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OVER_TEMP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNDER_TEMP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_GAP       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_MODS  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_VOLTAGE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_TEMP    = 3'd7;

    // Status codes, in priority order.
    localparam logic [CODE_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [CODE_W-1:0] STATUS_OVERVOLT   = 3'd1;
    localparam logic [CODE_W-1:0] STATUS_UNDERVOLT  = 3'd2;
    localparam logic [CODE_W-1:0] STATUS_OVERTEMP   = 3'd3;
    localparam logic [CODE_W-1:0] STATUS_UNDERTEMP  = 3'd4;
    localparam logic [CODE_W-1:0] STATUS_COMM       = 3'd5;
    localparam logic [CODE_W-1:0] STATUS_IMBALANCE  = 3'd6;

    // Item kinds.
    localparam logic KIND_EVALUATE = 1'b0;
    localparam logic KIND_CLEAR    = 1'b1;

    typedef struct packed {
        logic [LIM_MV_W-1:0]      over_voltage_mv;
        logic [LIM_MV_W-1:0]      under_voltage_mv;
        logic signed [TEMP_W-1:0] over_temp_deci;
        logic signed [TEMP_W-1:0] under_temp_deci;
        logic [LIM_MV_W-1:0]      cell_gap_mv;
        logic [MOD_W-1:0]         expected_modules;
        logic [LIM_MV_W-1:0]      charge_voltage_mv;
        logic signed [TEMP_W-1:0] charge_temp_deci;
    } bfm_cfg_t;

    typedef struct packed {
        logic                     kind;
        logic                     has_data;
        logic [MV_W-1:0]          high_cell_mv;
        logic [MV_W-1:0]          low_cell_mv;
        logic signed [TEMP_W-1:0] high_temp_deci;
        logic signed [TEMP_W-1:0] low_temp_deci;
        logic [TIME_W-1:0]        now_ms;
        logic [MOD_W-1:0]         alive_modules;
    } bfm_item_t;

    typedef struct packed {
        logic              over_volt_flag;
        logic              under_volt_flag;
        logic              over_temp_flag;
        logic              under_temp_flag;
        logic              imbalance_flag;
        logic              comm_flag;
        logic              debounce_running;
        logic [TIME_W-1:0] debounce_start_ms;
    } bfm_state_t;

    typedef struct packed {
        logic              all_ok;
        logic [CODE_W-1:0] status_code;
        logic              charge_allowed;
        logic              discharge_allowed;
    } bfm_result_t;

endpackage

/* src/bfm_cfg.sv */
// Configuration register file of the battery fault monitor.
module bfm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [bfm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bfm_pkg::bfm_cfg_t                 cfg
);
    import bfm_pkg::*;

    bfm_cfg_t cfg_reg;
    bfm_cfg_t cfg_next;

    // Decode a write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                REG_OVER_VOLTAGE:   cfg_next.over_voltage_mv   = cfg_wdata[LIM_MV_W-1:0];
                REG_UNDER_VOLTAGE:  cfg_next.under_voltage_mv  = cfg_wdata[LIM_MV_W-1:0];
                REG_OVER_TEMP:      cfg_next.over_temp_deci    = $signed(cfg_wdata[TEMP_W-1:0]);
                REG_UNDER_TEMP:     cfg_next.under_temp_deci   = $signed(cfg_wdata[TEMP_W-1:0]);
                REG_CELL_GAP:       cfg_next.cell_gap_mv       = cfg_wdata[LIM_MV_W-1:0];
                REG_EXPECTED_MODS:  cfg_next.expected_modules  = cfg_wdata[MOD_W-1:0];
                REG_CHARGE_VOLTAGE: cfg_next.charge_voltage_mv = cfg_wdata[LIM_MV_W-1:0];
                REG_CHARGE_TEMP:    cfg_next.charge_temp_deci  = $signed(cfg_wdata[TEMP_W-1:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers with their power-on limits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.over_voltage_mv   <= 14'd4200;
            cfg_reg.under_voltage_mv  <= 14'd3000;
            cfg_reg.over_temp_deci    <= 12'sd650;
            cfg_reg.under_temp_deci   <= -12'sd100;
            cfg_reg.cell_gap_mv       <= 14'd200;
            cfg_reg.expected_modules  <= '0;
            cfg_reg.charge_voltage_mv <= 14'd4100;
            cfg_reg.charge_temp_deci  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/bfm_eval.sv */
// Fault flag update and result evaluation for one check item.
module bfm_eval (
    input  bfm_pkg::bfm_cfg_t    cfg,
    input  bfm_pkg::bfm_item_t   item,
    input  bfm_pkg::bfm_state_t  state,
    output bfm_pkg::bfm_state_t  state_next,
    output bfm_pkg::bfm_result_t result
);
    import bfm_pkg::*;

    logic signed [17:0] hi_mv;
    logic signed [17:0] lo_mv;
    logic signed [17:0] ov_set;
    logic signed [17:0] ov_clr;
    logic signed [17:0] uv_set;
    logic signed [17:0] uv_clr;
    logic signed [17:0] gap_lim;
    logic signed [17:0] chg_v;
    logic signed [17:0] gap;
    logic signed [20:0] gap_x5;
    logic signed [20:0] gap_lim_x4;
    logic signed [12:0] hi_t;
    logic signed [12:0] lo_t;
    logic signed [12:0] ot_set;
    logic signed [12:0] ot_clr;
    logic signed [12:0] ut_set;
    logic signed [12:0] ut_clr;
    logic signed [12:0] chg_t;
    logic [TIME_W-1:0]  elapsed;
    logic               insane_mv;
    logic               modules_ok;
    logic               ok;

    // Widen every operand so limit minus hysteresis never wraps.
    always_comb
    begin
        hi_mv      = $signed({2'b00, item.high_cell_mv});
        lo_mv      = $signed({2'b00, item.low_cell_mv});
        ov_set     = $signed({4'b0000, cfg.over_voltage_mv});
        ov_clr     = ov_set - 18'(OV_CLEAR_MV);
        uv_set     = $signed({4'b0000, cfg.under_voltage_mv});
        uv_clr     = uv_set + 18'(UV_HYSTERESIS_MV);
        gap_lim    = $signed({4'b0000, cfg.cell_gap_mv});
        chg_v      = $signed({4'b0000, cfg.charge_voltage_mv});
        gap        = hi_mv - lo_mv;
        gap_x5     = (21'(gap) <<< 2) + 21'(gap);
        gap_lim_x4 = 21'(gap_lim) <<< 2;
        hi_t       = 13'(item.high_temp_deci);
        lo_t       = 13'(item.low_temp_deci);
        ot_set     = 13'(cfg.over_temp_deci);
        ot_clr     = ot_set - 13'(TEMP_HYSTERESIS_DECI);
        ut_set     = 13'(cfg.under_temp_deci);
        ut_clr     = ut_set + 13'(TEMP_HYSTERESIS_DECI);
        chg_t      = 13'(cfg.charge_temp_deci);
        elapsed    = item.now_ms - state.debounce_start_ms;
        insane_mv  = hi_mv > 18'(SANE_LIMIT_MV);
        modules_ok = (cfg.expected_modules[MODULE_SLOTS-1:0]
                      & ~item.alive_modules[MODULE_SLOTS-1:0]) == '0;
    end

    // Flag update with hysteresis.
    always_comb
    begin
        state_next = state;
        ok         = 1'b1;
        if (item.kind == KIND_CLEAR)
        begin
            state_next = '0;
        end
        else if (item.has_data && insane_mv)
        begin
            state_next.over_volt_flag = 1'b1;
            ok = 1'b0;
        end
        else if (item.has_data)
        begin
            if (hi_mv > ov_set)
                state_next.over_volt_flag = 1'b1;
            else if (hi_mv < ov_clr)
                state_next.over_volt_flag = 1'b0;

            // Under voltage is debounced by a wrapping millisecond timer.
            if (lo_mv < uv_set)
            begin
                if (!state.debounce_running)
                begin
                    state_next.debounce_running  = 1'b1;
                    state_next.debounce_start_ms = item.now_ms;
                end
                else if (elapsed > TIME_W'(DEBOUNCE_MS))
                begin
                    state_next.under_volt_flag = 1'b1;
                end
            end
            else if (lo_mv > uv_clr)
            begin
                state_next.under_volt_flag   = 1'b0;
                state_next.debounce_running  = 1'b0;
                state_next.debounce_start_ms = '0;
            end

            if (hi_t > ot_set)
                state_next.over_temp_flag = 1'b1;
            else if (hi_t < ot_clr)
                state_next.over_temp_flag = 1'b0;

            if (lo_t < ut_set)
                state_next.under_temp_flag = 1'b1;
            else if (lo_t > ut_clr)
                state_next.under_temp_flag = 1'b0;

            // Imbalance clears once the gap drops below 0.8 of the limit.
            if (gap > gap_lim)
                state_next.imbalance_flag = 1'b1;
            else if (gap_x5 < gap_lim_x4)
                state_next.imbalance_flag = 1'b0;

            // Missing modules are ignored during the start-up grace time.
            if (!modules_ok && (item.now_ms > TIME_W'(GRACE_MS)))
                state_next.comm_flag = 1'b1;
            else if (modules_ok)
                state_next.comm_flag = 1'b0;

            ok = !(state_next.over_volt_flag || state_next.under_volt_flag
                   || state_next.over_temp_flag || state_next.under_temp_flag
                   || state_next.comm_flag);
        end
    end

    // Status by priority and the charge and discharge permissions.
    always_comb
    begin
        result.all_ok = ok;
        if (state_next.over_volt_flag)
            result.status_code = STATUS_OVERVOLT;
        else if (state_next.under_volt_flag)
            result.status_code = STATUS_UNDERVOLT;
        else if (state_next.over_temp_flag)
            result.status_code = STATUS_OVERTEMP;
        else if (state_next.under_temp_flag)
            result.status_code = STATUS_UNDERTEMP;
        else if (state_next.comm_flag)
            result.status_code = STATUS_COMM;
        else if (state_next.imbalance_flag)
            result.status_code = STATUS_IMBALANCE;
        else
            result.status_code = STATUS_OK;
        result.charge_allowed = !state_next.over_volt_flag && !state_next.over_temp_flag
                                && (lo_t >= chg_t) && (hi_mv <= chg_v);
        result.discharge_allowed = !state_next.under_volt_flag && !state_next.over_temp_flag
                                   && (lo_mv >= 18'(DISCHARGE_LIMIT_MV));
    end

endmodule

/* src/battery_fault_monitor.sv */
// Top level of the battery fault monitor: input stage, evaluation and result stage.
//
//  Channel  Direction  Signals                          Content
//  s_*      in         s_tvalid s_tready s_tdata s_tuser  one check or clear item
//  m_*      out        m_tvalid m_tready m_tdata          one status result per item
//  cfg_*    in         cfg_wen cfg_addr cfg_wdata         limit register writes
//
// An item passes from the input transfer through the input register, then through
// the flag logic into the result register.
// One item is accepted every cycle while the result side keeps taking data.
// A stalled result holds both stages; the input side stays ready whenever the
// input register is empty or moves forward in the same cycle.
// Reset clears all fault flags, the debounce timer and loads the default limits.
module battery_fault_monitor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Bits: high_cell_mv[15:0], low_cell_mv[31:16], high_temp_deci[43:32],
    // low_temp_deci[55:44], now_ms[87:56], alive_modules[107:88], zero pad.
    input  logic [bfm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // Bits: kind[0], has_data[1].
    input  logic [bfm_pkg::IN_TUSER_W-1:0]       s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Bits: all_ok[0], status_code[3:1], charge_allowed[4],
    // discharge_allowed[5], zero pad.
    output logic [bfm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                                 cfg_wen,
    input  logic [bfm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import bfm_pkg::*;

    bfm_cfg_t    cfg;
    bfm_item_t   in_item;
    bfm_item_t   item_reg;
    logic        item_valid_reg;
    bfm_state_t  state_reg;
    bfm_state_t  state_next;
    bfm_result_t eval_result;
    bfm_result_t result_reg;
    logic        result_valid_reg;
    logic        result_free;
    logic        eval_fire;
    logic        in_fire;

    bfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the incoming transfer.
    always_comb
    begin
        in_item.kind           = s_tuser[0];
        in_item.has_data       = s_tuser[1];
        in_item.high_cell_mv   = s_tdata[15:0];
        in_item.low_cell_mv    = s_tdata[31:16];
        in_item.high_temp_deci = $signed(s_tdata[43:32]);
        in_item.low_temp_deci  = $signed(s_tdata[55:44]);
        in_item.now_ms         = s_tdata[87:56];
        in_item.alive_modules  = s_tdata[107:88];
    end

    // Handshake between the two stages.
    assign result_free = !result_valid_reg || m_tready;
    assign eval_fire   = item_valid_reg && result_free;
    assign s_tready    = !item_valid_reg || eval_fire;
    assign in_fire     = s_tvalid && s_tready;

    bfm_eval u_eval (
        .cfg        (cfg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (eval_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item;
        end
    end

    // Fault flags advance once per evaluated item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (eval_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            result_reg <= eval_result;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {2'b00, result_reg.discharge_allowed, result_reg.charge_allowed,
                       result_reg.status_code, result_reg.all_ok};

endmodule
